/* rtl/rlb_pkg.sv */
// Shared types and codes for the timed RGB LED blinker.
package rlb_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_SOLID = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RATE_SLOW   = 2'd0,
    RATE_NORMAL = 2'd1,
    RATE_FAST   = 2'd2,
    RATE_EXTRA  = 2'd3
  } rate_t;

  typedef enum logic [1:0] {
    REG_SLOW_PERIOD   = 2'd0,
    REG_NORMAL_PERIOD = 2'd1,
    REG_FAST_PERIOD   = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  localparam int unsigned InDataWidth  = 72;
  localparam int unsigned OutDataWidth = 32;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [15:0] SlowPeriodReset   = 16'd1000;
  localparam logic [15:0] NormalPeriodReset = 16'd500;
  localparam logic [15:0] FastPeriodReset   = 16'd250;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  localparam colour_t ColourDark = '{red: 8'd0, green: 8'd0, blue: 8'd0};

endpackage

/* rtl/rgb_led_timed_blinker_top.sv */
// Timed RGB LED blinker: tick-driven solid and blink commands with a registered result.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready       | tuser mode, tdata colours, duration, rate
//  m_*     | out | m_tvalid / m_tready       | tdata levels, accepted, running
//  cfg_*   | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data (blink half-periods)
//
// One item a cycle: the state update and result are one pass of logic into the
// result register, so a result appears the cycle after its item is taken.
// s_tready is high while the result register is empty or being drained this cycle.
// A stalled result holds, and the input stalls behind it; cfg_ready is always high.
// Synchronous reset clears the LED state, restores the default periods and drops m_tvalid.
module rgb_led_timed_blinker_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tuser: mode[1:0]
  input  logic [1:0]                        s_tuser,
  // tdata: first_red[7:0], first_green[15:8], first_blue[23:16], second_red[31:24],
  //        second_green[39:32], second_blue[47:40], duration_ms[63:48],
  //        rate_select[65:64], zero[71:66]
  input  logic [rlb_pkg::InDataWidth-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata: red_level[7:0], green_level[15:8], blue_level[23:16], accepted[24],
  //        running[25], zero[31:26]
  output logic [rlb_pkg::OutDataWidth-1:0]  m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rlb_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [rlb_pkg::CfgDataWidth-1:0]  cfg_data
);
  import rlb_pkg::*;

  // blink half-periods
  logic [15:0] slow_period;
  logic [15:0] normal_period;
  logic [15:0] fast_period;

  // LED state
  logic [15:0] remaining_ms, remaining_ms_next;
  logic [15:0] blink_countdown, blink_countdown_next;
  logic        active_flag, active_flag_next;
  logic        blink_enabled, blink_enabled_next;
  logic        show_second, show_second_next;
  logic [15:0] chosen_period, chosen_period_next;
  colour_t     first_colour, first_colour_next;
  colour_t     second_colour, second_colour_next;
  colour_t     drive_colour, drive_colour_next;
  logic        taken_next;

  // result register
  colour_t     res_colour;
  logic        res_accepted;
  logic        res_running;

  mode_t       in_mode;
  rate_t       in_rate;
  colour_t     in_first;
  colour_t     in_second;
  logic [15:0] in_duration;
  logic [15:0] rate_period;
  logic        busy;
  logic        s_accept;

  assign in_mode     = mode_t'(s_tuser);
  assign in_first    = '{red: s_tdata[7:0], green: s_tdata[15:8], blue: s_tdata[23:16]};
  assign in_second   = '{red: s_tdata[31:24], green: s_tdata[39:32], blue: s_tdata[47:40]};
  assign in_duration = s_tdata[63:48];
  assign in_rate     = rate_t'(s_tdata[65:64]);

  assign s_tready  = !m_tvalid || m_tready;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    case (in_rate)
      RATE_SLOW:   rate_period = slow_period;
      RATE_NORMAL: rate_period = normal_period;
      default:     rate_period = fast_period;
    endcase
  end

  assign busy = active_flag && (remaining_ms != 16'd0);

  always_comb begin
    remaining_ms_next    = remaining_ms;
    blink_countdown_next = blink_countdown;
    active_flag_next     = active_flag;
    blink_enabled_next   = blink_enabled;
    show_second_next     = show_second;
    chosen_period_next   = chosen_period;
    first_colour_next    = first_colour;
    second_colour_next   = second_colour;
    drive_colour_next    = drive_colour;
    taken_next           = 1'b0;
    case (in_mode)
      MODE_TICK: begin
        if (active_flag) begin
          if (remaining_ms == 16'd0) begin
            // duration over: go dark and clear
            remaining_ms_next    = 16'd0;
            blink_countdown_next = 16'd0;
            active_flag_next     = 1'b0;
            blink_enabled_next   = 1'b0;
            show_second_next     = 1'b0;
            chosen_period_next   = 16'd0;
            first_colour_next    = ColourDark;
            second_colour_next   = ColourDark;
            drive_colour_next    = ColourDark;
          end else begin
            remaining_ms_next = remaining_ms - 16'd1;
            if (blink_enabled) begin
              if (blink_countdown == 16'd0) begin
                drive_colour_next    = show_second ? second_colour : first_colour;
                show_second_next     = !show_second;
                blink_countdown_next = chosen_period;
              end else begin
                blink_countdown_next = blink_countdown - 16'd1;
              end
            end
          end
        end
      end
      MODE_SOLID, MODE_BLINK: begin
        if (!busy) begin
          taken_next        = 1'b1;
          active_flag_next  = 1'b1;
          remaining_ms_next = in_duration;
          first_colour_next = in_first;
          drive_colour_next = in_first;
          if (in_mode == MODE_BLINK) begin
            blink_enabled_next   = 1'b1;
            second_colour_next   = in_second;
            chosen_period_next   = rate_period;
            blink_countdown_next = rate_period;
            show_second_next     = 1'b1;
          end
        end
      end
      default: begin
        // unused mode: no time passes
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_period   <= SlowPeriodReset;
      normal_period <= NormalPeriodReset;
      fast_period   <= FastPeriodReset;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_SLOW_PERIOD:   slow_period   <= cfg_data;
        REG_NORMAL_PERIOD: normal_period <= cfg_data;
        REG_FAST_PERIOD:   fast_period   <= cfg_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_ms    <= 16'd0;
      blink_countdown <= 16'd0;
      active_flag     <= 1'b0;
      blink_enabled   <= 1'b0;
      show_second     <= 1'b0;
      chosen_period   <= 16'd0;
      first_colour    <= ColourDark;
      second_colour   <= ColourDark;
      drive_colour    <= ColourDark;
    end else if (s_accept) begin
      remaining_ms    <= remaining_ms_next;
      blink_countdown <= blink_countdown_next;
      active_flag     <= active_flag_next;
      blink_enabled   <= blink_enabled_next;
      show_second     <= show_second_next;
      chosen_period   <= chosen_period_next;
      first_colour    <= first_colour_next;
      second_colour   <= second_colour_next;
      drive_colour    <= drive_colour_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      res_colour   <= drive_colour_next;
      res_accepted <= taken_next;
      res_running  <= active_flag_next;
    end
  end

  assign m_tdata = {6'd0, res_running, res_accepted,
                    res_colour.blue, res_colour.green, res_colour.red};

endmodule

/* rtl/rlb_checker.sv */
// Port-level checks for the timed RGB LED blinker, bound to its top level.
module rlb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [rlb_pkg::OutDataWidth-1:0]  m_tdata
);
  import rlb_pkg::*;

  // no result may follow straight out of reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // an empty result register must never stall the input
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // a taken command always leaves the block running
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tdata[24] |-> m_tdata[25])
    else $error("command taken but not running");

  // the LED is dark whenever nothing runs
  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tdata[25] |-> m_tdata[23:0] == 24'd0)
    else $error("LED lit while idle");

endmodule

bind rgb_led_timed_blinker_top rlb_checker u_rlb_checker (.*);

/* tb/sv/rgb_led_timed_blinker_top_tb.sv */
// Self-checking testbench for the timed RGB LED blinker: directed and random items, scoreboard.
import rlb_pkg::*;

class led_level_scoreboard;
  typedef struct {
    colour_t lvl;
    bit      taken;
    bit      on;
  } led_result_t;

  led_result_t due[$];
  logic [15:0] half_period [4];
  logic [15:0] ms_left;
  logic [15:0] phase_left;
  logic [15:0] period_held;
  bit          on;
  bit          blinking;
  bit          second_next;
  colour_t     first_c;
  colour_t     second_c;
  colour_t     drive_c;
  int unsigned mismatches;

  function new();
    half_period[REG_SLOW_PERIOD]   = SlowPeriodReset;
    half_period[REG_NORMAL_PERIOD] = NormalPeriodReset;
    half_period[REG_FAST_PERIOD]   = FastPeriodReset;
    half_period[REG_UNUSED]        = '0;
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    ms_left     = '0;
    phase_left  = '0;
    period_held = '0;
    on          = 1'b0;
    blinking    = 1'b0;
    second_next = 1'b0;
    first_c     = ColourDark;
    second_c    = ColourDark;
    drive_c     = ColourDark;
  endfunction

  function int pending();
    return due.size();
  endfunction

  function void set_period(logic [1:0] idx, logic [15:0] v);
    half_period[idx] = v;
  endfunction

  // One millisecond passes: the duration and the blink phase run down one
  function void advance_ms();
    if (!on) return;
    if (ms_left == 0) begin
      clear();
      return;
    end
    ms_left = ms_left - 16'd1;
    if (blinking) begin
      if (phase_left == 0) begin
        drive_c     = second_next ? second_c : first_c;
        second_next = !second_next;
        phase_left  = period_held;
      end else begin
        phase_left = phase_left - 16'd1;
      end
    end
  endfunction

  function void take_item(logic [1:0] mode_bits, logic [InDataWidth-1:0] d);
    led_result_t r;
    bit          taken;
    taken = 1'b0;
    case (mode_t'(mode_bits))
      MODE_TICK: advance_ms();
      MODE_SOLID, MODE_BLINK: begin
        if (!(on && ms_left != 0)) begin
          taken   = 1'b1;
          on      = 1'b1;
          ms_left = d[63:48];
          first_c = '{red: d[7:0], green: d[15:8], blue: d[23:16]};
          drive_c = first_c;
          if (mode_t'(mode_bits) == MODE_BLINK) begin
            case (rate_t'(d[65:64]))
              RATE_SLOW:   period_held = half_period[REG_SLOW_PERIOD];
              RATE_NORMAL: period_held = half_period[REG_NORMAL_PERIOD];
              default:     period_held = half_period[REG_FAST_PERIOD];
            endcase
            blinking    = 1'b1;
            second_c    = '{red: d[31:24], green: d[39:32], blue: d[47:40]};
            phase_left  = period_held;
            second_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.lvl   = drive_c;
    r.taken = taken;
    r.on    = on;
    due.push_back(r);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task check_levels(logic [OutDataWidth-1:0] d);
    led_result_t w;
    if (due.size() == 0) begin
      report($sformatf("result %h arrived with nothing due", d));
      return;
    end
    w = due.pop_front();
    check_field("red_level", d[7:0], w.lvl.red);
    check_field("green_level", d[15:8], w.lvl.green);
    check_field("blue_level", d[23:16], w.lvl.blue);
    check_field("accepted", {7'd0, d[24]}, {7'd0, w.taken});
    check_field("running", {7'd0, d[25]}, {7'd0, w.on});
  endtask
endclass

module rgb_led_timed_blinker_top_tb;
  localparam int unsigned CycleLimit = 200000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [1:0]              s_tuser = '0;
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b1;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  led_level_scoreboard sb;
  bit                  gaps_on = 1'b0;
  bit                  stalls_on = 1'b0;
  int unsigned         sent = 0;
  int unsigned         cycles = 0;
  int unsigned         hold_left = 0;

  rgb_led_timed_blinker_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("rgb_led_timed_blinker_top regression: fail");
      $finish;
    end
  end

  // Register writes, then items, then results: all seen with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_period(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.take_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_levels(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || !stalls_on) begin
      m_tready  <= 1'b1;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_tready  <= 1'b0;
      hold_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic colour_t rand_colour();
    colour_t c;
    c.red   = 8'($urandom);
    c.green = 8'($urandom);
    c.blue  = 8'($urandom);
    return c;
  endfunction

  function automatic logic [InDataWidth-1:0] cmd_bits(colour_t a, colour_t b,
                                                      logic [15:0] dur, rate_t r);
    return {6'b0, r, dur, b.blue, b.green, b.red, a.blue, a.green, a.red};
  endfunction

  function automatic logic [InDataWidth-1:0] noise_bits();
    return cmd_bits(rand_colour(), rand_colour(), 16'($urandom), rate_t'($urandom_range(0, 3)));
  endfunction

  task automatic send_item(mode_t m, logic [InDataWidth-1:0] d);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= m;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_periods(logic [15:0] slow, logic [15:0] normal,
                                 logic [15:0] fast, bit touch_spare);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_SLOW_PERIOD;
    cfg_data  <= slow;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_NORMAL_PERIOD;
    cfg_data  <= normal;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_FAST_PERIOD;
    cfg_data  <= fast;
    do @(posedge clk); while (!cfg_ready);
    if (touch_spare) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= 16'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One command, then enough ticks to run it out, with stray commands mixed in.
  // Strays after the duration carry zero duration, so the block is idle at the end.
  task automatic run_burst();
    mode_t       m;
    mode_t       stray;
    logic [15:0] dur;
    int unsigned ticks;
    m     = ($urandom_range(0, 1) != 0) ? MODE_BLINK : MODE_SOLID;
    dur   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(13, 60))
                                        : 16'($urandom_range(0, 12));
    ticks = dur + $urandom_range(1, 3);
    send_item(m, cmd_bits(rand_colour(), rand_colour(), dur, rate_t'($urandom_range(0, 3))));
    for (int unsigned i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        stray = ($urandom_range(0, 7) == 0) ? MODE_NONE : mode_t'($urandom_range(1, 2));
        send_item(stray, cmd_bits(rand_colour(), rand_colour(),
                                  (i < dur) ? 16'($urandom) : 16'd0,
                                  rate_t'($urandom_range(0, 3))));
      end
      send_item(MODE_TICK, noise_bits());
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // default periods: idle tick, ignored mode, zero duration, command at the last ms
    send_item(MODE_TICK, '0);
    send_item(MODE_NONE, {6'b0, {66{1'b1}}});
    send_item(MODE_SOLID, cmd_bits(colour_t'(24'hFFFFFF), ColourDark, 16'd0, RATE_SLOW));
    send_item(MODE_BLINK, cmd_bits(colour_t'(24'h00FF00), colour_t'(24'hFF00FF), 16'd3,
                                   RATE_SLOW));
    send_item(MODE_SOLID, cmd_bits(colour_t'(24'hFFFFFF), colour_t'(24'hFFFFFF), 16'd9,
                                   RATE_FAST));
    repeat (3) send_item(MODE_TICK, '0);
    send_item(MODE_SOLID, cmd_bits(colour_t'(24'h123456), ColourDark, 16'd1, RATE_NORMAL));
    repeat (3) send_item(MODE_TICK, '0);

    // zero period toggles every tick; rate three falls back to fast
    program_periods(16'd0, 16'd1, 16'hFFFF, 1'b0);
    send_item(MODE_BLINK, cmd_bits(colour_t'(24'hAA55AA), colour_t'(24'h55AA55), 16'd4,
                                   RATE_SLOW));
    repeat (5) send_item(MODE_TICK, '0);
    send_item(MODE_BLINK, cmd_bits(colour_t'(24'h0F0F0F), colour_t'(24'hFFFFFF), 16'd2,
                                   RATE_EXTRA));
    send_item(MODE_BLINK, cmd_bits(colour_t'(24'hFFFFFF), colour_t'(24'hFFFFFF), 16'hFFFF,
                                   RATE_EXTRA));
    repeat (3) send_item(MODE_TICK, '0);
    send_item(MODE_NONE, '0);

    while (sent < 300) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      run_burst();
    end

    program_periods(16'hFFFF, 16'd0, 16'd3, 1'b1);
    while (sent < 600) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      run_burst();
    end

    // last part runs flat out on both sides
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    program_periods(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                    16'($urandom_range(0, 6)), 1'b0);
    while (sent < 830) run_burst();

    // longest duration last, since nothing can clear it in a short run
    send_item(MODE_BLINK, cmd_bits(rand_colour(), rand_colour(), 16'hFFFF,
                                   rate_t'($urandom_range(0, 3))));
    repeat (10) send_item(MODE_TICK, noise_bits());
    send_item(mode_t'($urandom_range(1, 2)), noise_bits());

    drain();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("rgb_led_timed_blinker_top regression: pass");
    end else begin
      $display("rgb_led_timed_blinker_top regression: fail");
    end
    $finish;
  end
endmodule

/* rgb_led_timed_blinker_top.f */
rtl/rlb_pkg.sv
rtl/rgb_led_timed_blinker_top.sv
rtl/rlb_checker.sv
tb/sv/rgb_led_timed_blinker_top_tb.sv
